FILE: rtl/bta_pkg.sv
package bta_pkg;

	// Store geometry and heap limits.
	localparam int unsigned HEAP_WORDS   = 16384;
	localparam int unsigned IDX_W        = $clog2(HEAP_WORDS);
	localparam int unsigned HEAP_LIMIT   = (HEAP_WORDS * 4 < 65536) ? HEAP_WORDS * 4 : 65536;
	localparam int unsigned RESET_EXTEND = 4096;

	// Reset layout: prologue tags, one free page, epilogue.
	localparam logic [31:0] PROLOGUE_TAG = 32'd9;
	localparam logic [31:0] EPILOGUE_TAG = 32'd1;
	localparam logic [31:0] PAGE_TAG     = 32'(RESET_EXTEND);
	localparam int unsigned PAGE_HDR_IDX = 3;
	localparam int unsigned PAGE_FTR_IDX = (16 + RESET_EXTEND - 8) / 4;
	localparam int unsigned EPI_IDX      = (16 + RESET_EXTEND - 4) / 4;
	localparam bit          PAGE_FITS    = (16 + RESET_EXTEND) <= HEAP_LIMIT;
	localparam logic [16:0] BREAK_RESET  = PAGE_FITS ? 17'(16 + RESET_EXTEND) : 17'd16;

	// Action and status codes.
	localparam logic       ACT_ALLOC  = 1'b0;
	localparam logic       ACT_FREE   = 1'b1;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ZERO    = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;

	// One access to the tag memory.
	typedef struct packed {
		logic        we;
		logic [31:0] addr;
		logic [31:0] wdata;
	} mem_req_t;

	typedef enum logic [5:0] {
		S_CLEAR, S_IDLE,
		S_F_R, S_F_HW, S_F_FW,
		S_A_CHK, S_A_TST,
		S_G_CHK, S_G_HW, S_G_FW, S_G_EW,
		S_M_R1, S_M_R2, S_M_R3, S_M_R4, S_M_R5, S_M_DEC,
		S_M_BR, S_M_BW, S_M_NR1, S_M_NR2, S_M_NW, S_M_PR, S_M_PRET, S_M_RET,
		S_P_R, S_P_HW, S_P_HR, S_P_FW, S_P_NR, S_P_NW, S_P_NR2, S_P_NFW,
		S_DONE
	} state_t;

	// Word written by the clearing pass at a given index.
	function automatic logic [31:0] init_word(input logic [IDX_W-1:0] idx);
		logic [31:0] v;
		v = '0;
		if (idx == IDX_W'(1) || idx == IDX_W'(2))
			v = PROLOGUE_TAG;
		if (PAGE_FITS) begin
			if (idx == IDX_W'(PAGE_HDR_IDX))
				v = PAGE_TAG;
			else if (idx == IDX_W'(PAGE_FTR_IDX))
				v = PAGE_TAG;
			else if (idx == IDX_W'(EPI_IDX))
				v = EPILOGUE_TAG;
		end else if (idx == IDX_W'(PAGE_HDR_IDX)) begin
			v = EPILOGUE_TAG;
		end
		return v;
	endfunction

	function automatic logic [31:0] tag_size(input logic [31:0] t);
		return {t[31:3], 3'b000};
	endfunction

endpackage

FILE: rtl/boundary_tag_heap_allocator_unit.sv
// Channel  Direction  Signals
// config   in         cfg_we, cfg_wdata (extend_bytes)
// request  in         in_valid/in_ready, action, req_size, block_addr
// result   out        out_valid/out_ready, result_addr, status
//
// An allocate walks the block tags from the roving start, then places the block
// by writing its header and footer and, when it is split, the remainder's tags;
// growing the heap writes a new page and merges it first. A free writes the
// block's tags and then merges; every item ends in the result state, and the
// tag memory has a single port. After reset a clearing pass writes the initial
// heap and no word is taken; a stalled result register holds the next result in the controller.
module boundary_tag_heap_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [15:0] req_size,
	input  logic [15:0] block_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result_addr,
	output logic [1:0]  status
);
	import bta_pkg::*;

	logic [16:0] extend_q;
	logic        out_valid_q;
	logic [15:0] result_addr_q;
	logic [1:0]  status_q;
	logic        res_valid, res_ready;
	logic [15:0] res_addr;
	logic [1:0]  res_status;
	mem_req_t    mreq;
	logic [31:0] mem_rdata;

	// Page size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			extend_q <= 17'(RESET_EXTEND);
		else if (cfg_we)
			extend_q <= cfg_wdata;
	end

	bta_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.req_size    (req_size),
		.block_addr  (block_addr),
		.extend_bytes(extend_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_addr    (res_addr),
		.res_status  (res_status),
		.mreq        (mreq),
		.rd          (mem_rdata)
	);

	bta_tag_mem u_mem (
		.clk  (clk),
		.req  (mreq),
		.rdata(mem_rdata)
	);

	// Output register for the result word.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_valid && res_ready)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			result_addr_q <= res_addr;
			status_q      <= res_status;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_addr = result_addr_q;
	assign status      = status_q;

endmodule

FILE: rtl/bta_tag_mem.sv
module bta_tag_mem (
	input  logic              clk,
	input  bta_pkg::mem_req_t req,
	output logic [31:0]       rdata
);
	import bta_pkg::*;

	logic [31:0]      mem [HEAP_WORDS];
	logic [31:0]      rdata_q;
	logic             oor_q;
	logic [IDX_W-1:0] idx;
	logic             in_range;

	// Byte address to word index; addresses past the store read as zero.
	assign idx      = req.addr[IDX_W+1:2];
	assign in_range = (req.addr >> (IDX_W + 2)) == 32'd0;

	always_ff @(posedge clk) begin
		if (req.we && in_range)
			mem[idx] <= req.wdata;
		rdata_q <= mem[idx];
		oor_q   <= !in_range;
	end

	assign rdata = oor_q ? 32'd0 : rdata_q;

endmodule

FILE: rtl/bta_ctrl.sv
module bta_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic [15:0]       req_size,
	input  logic [15:0]       block_addr,
	input  logic [16:0]       extend_bytes,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [15:0]       res_addr,
	output logic [1:0]        res_status,
	output bta_pkg::mem_req_t mreq,
	input  logic [31:0]       rd
);
	import bta_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] clr_q;
	logic [16:0]      asize_q;
	logic [32:0]      w_q;
	logic [31:0]      b_q, p_q, n_q, s_q, pt_q, hv_q, left_q;
	logic             pa_q, split_q, grow_q;
	logic [16:0]      hb_q;
	logic [15:0]      ss_q;
	logic [17:0]      gsize_q;
	logic [15:0]      res_addr_q;
	logic [1:0]       res_status_q;

	logic [31:0] rsz;
	logic [31:0] asize32;
	logic [16:0] gmin;
	logic [14:0] gunits;
	logic [17:0] gsize;
	logic        split;

	assign rsz     = tag_size(rd);
	assign asize32 = {15'd0, asize_q};
	assign gmin    = (asize_q > extend_bytes) ? asize_q : extend_bytes;
	assign gunits  = {1'b0, gmin[16:3]} + {14'd0, gmin[3]};
	assign gsize   = {gunits, 3'b000};
	assign split   = (rsz >= asize32) && ((rsz - asize32) >= 32'd16);

	assign in_ready   = state_q == S_IDLE;
	assign res_valid  = state_q == S_DONE;
	assign res_addr   = res_addr_q;
	assign res_status = res_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	// Next state and the one memory access of each state.
	always_comb begin
		state_d    = state_q;
		mreq.we    = 1'b0;
		mreq.addr  = b_q - 32'd4;
		mreq.wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				mreq.we    = 1'b1;
				mreq.addr  = {{(30-IDX_W){1'b0}}, clr_q, 2'b00};
				mreq.wdata = init_word(clr_q);
				if (clr_q == {IDX_W{1'b1}})
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					if (action == ACT_FREE)
						state_d = S_F_R;
					else if (req_size == 16'd0)
						state_d = S_DONE;
					else
						state_d = S_A_CHK;
				end
			end
			S_F_R: state_d = S_F_HW;
			S_F_HW: begin
				mreq.we    = 1'b1;
				mreq.wdata = rsz;
				state_d    = S_F_FW;
			end
			S_F_FW: begin
				mreq.we    = 1'b1;
				mreq.addr  = b_q + s_q - 32'd8;
				mreq.wdata = s_q;
				state_d    = S_M_R1;
			end
			S_A_CHK: begin
				mreq.addr = w_q[31:0] - 32'd4;
				state_d   = (w_q > {16'd0, hb_q}) ? S_G_CHK : S_A_TST;
			end
			S_A_TST: begin
				if (rsz == 32'd0)
					state_d = S_G_CHK;
				else if (!rd[0] && rsz >= asize32)
					state_d = S_P_R;
				else
					state_d = S_A_CHK;
			end
			S_G_CHK: begin
				if ({2'b0, hb_q} + {1'b0, gsize} > 19'(HEAP_LIMIT))
					state_d = S_DONE;
				else
					state_d = S_G_HW;
			end
			S_G_HW: begin
				mreq.we    = 1'b1;
				mreq.wdata = {14'd0, gsize_q};
				state_d    = S_G_FW;
			end
			S_G_FW: begin
				mreq.we    = 1'b1;
				mreq.addr  = b_q + {14'd0, gsize_q} - 32'd8;
				mreq.wdata = {14'd0, gsize_q};
				state_d    = S_G_EW;
			end
			S_G_EW: begin
				mreq.we    = 1'b1;
				mreq.addr  = b_q + {14'd0, gsize_q} - 32'd4;
				mreq.wdata = EPILOGUE_TAG;
				state_d    = S_M_R1;
			end
			S_M_R1: begin
				mreq.addr = b_q - 32'd8;
				state_d   = S_M_R2;
			end
			S_M_R2: begin
				mreq.addr = b_q - rsz - 32'd4;
				state_d   = S_M_R3;
			end
			S_M_R3: begin
				mreq.addr = p_q + rsz - 32'd8;
				state_d   = S_M_R4;
			end
			S_M_R4: state_d = S_M_R5;
			S_M_R5: begin
				mreq.addr = b_q + rsz - 32'd4;
				state_d   = S_M_DEC;
			end
			S_M_DEC: begin
				mreq.wdata = s_q + (rd[0] ? 32'd0 : rsz) + (pa_q ? 32'd0 : pt_q);
				priority if (pa_q && rd[0]) begin
					state_d = S_M_RET;
				end else if (pa_q) begin
					mreq.we = 1'b1;
					state_d = S_M_BR;
				end else begin
					mreq.we   = 1'b1;
					mreq.addr = p_q - 32'd4;
					state_d   = rd[0] ? S_M_BR : S_M_NR1;
				end
			end
			S_M_BR: state_d = S_M_BW;
			S_M_BW: begin
				mreq.we    = 1'b1;
				mreq.addr  = b_q + rsz - 32'd8;
				mreq.wdata = s_q;
				state_d    = pa_q ? S_M_RET : S_M_PR;
			end
			S_M_NR1: state_d = S_M_NR2;
			S_M_NR2: begin
				mreq.addr = b_q + rsz - 32'd4;
				state_d   = S_M_NW;
			end
			S_M_NW: begin
				mreq.we    = 1'b1;
				mreq.addr  = n_q + rsz - 32'd8;
				mreq.wdata = s_q;
				state_d    = S_M_PR;
			end
			S_M_PR: begin
				mreq.addr = b_q - 32'd8;
				state_d   = S_M_PRET;
			end
			S_M_PRET: state_d = S_M_RET;
			S_M_RET: state_d = grow_q ? S_P_R : S_DONE;
			S_P_R: state_d = S_P_HW;
			S_P_HW: begin
				mreq.we    = 1'b1;
				mreq.wdata = split ? (asize32 | 32'd1) : (rsz | 32'd1);
				state_d    = S_P_HR;
			end
			S_P_HR: state_d = S_P_FW;
			S_P_FW: begin
				mreq.we    = 1'b1;
				mreq.addr  = b_q + rsz - 32'd8;
				mreq.wdata = hv_q;
				state_d    = split_q ? S_P_NR : S_DONE;
			end
			S_P_NR: state_d = S_P_NW;
			S_P_NW: begin
				mreq.we    = 1'b1;
				mreq.addr  = b_q + rsz - 32'd4;
				mreq.wdata = left_q;
				state_d    = S_P_NR2;
			end
			S_P_NR2: begin
				mreq.addr = n_q - 32'd4;
				state_d   = S_P_NFW;
			end
			S_P_NFW: begin
				mreq.we    = 1'b1;
				mreq.addr  = n_q + rsz - 32'd8;
				mreq.wdata = left_q;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (res_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers: clearing counter, heap break and roving start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			hb_q  <= BREAK_RESET;
			ss_q  <= 16'd16;
		end else begin
			if (state_q == S_CLEAR)
				clr_q <= clr_q + IDX_W'(1);
			if (state_q == S_G_CHK && state_d == S_G_HW)
				hb_q <= hb_q + gsize[16:0];
			if (state_q == S_M_RET)
				ss_q <= b_q[15:0];
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				b_q          <= {16'd0, block_addr};
				w_q          <= {17'd0, ss_q};
				asize_q      <= ({1'b0, req_size} + 17'd15) & ~17'd7;
				grow_q       <= 1'b0;
				res_addr_q   <= 16'd0;
				res_status_q <= (action == ACT_ALLOC && req_size == 16'd0) ? ST_ZERO : ST_OK;
			end
			S_F_HW: s_q <= rsz;
			S_A_TST: begin
				w_q        <= w_q + {1'b0, rsz};
				b_q        <= w_q[31:0];
				res_addr_q <= w_q[15:0];
			end
			S_G_CHK: begin
				b_q          <= {15'd0, hb_q};
				gsize_q      <= gsize;
				grow_q       <= 1'b1;
				res_addr_q   <= 16'd0;
				res_status_q <= (state_d == S_DONE) ? ST_NOSPACE : ST_OK;
			end
			S_M_R2: p_q <= b_q - rsz;
			S_M_R3: pt_q <= rsz;
			S_M_R4: pa_q <= rd[0];
			S_M_R5: s_q <= rsz;
			S_M_DEC: begin
				s_q <= s_q + (rd[0] ? 32'd0 : rsz) + (pa_q ? 32'd0 : pt_q);
			end
			S_M_NR2: n_q <= b_q + rsz;
			S_M_PRET: b_q <= b_q - rsz;
			S_M_RET: begin
				if (grow_q)
					res_addr_q <= b_q[15:0];
			end
			S_P_HW: begin
				split_q <= split;
				hv_q    <= split ? (asize32 | 32'd1) : (rsz | 32'd1);
				left_q  <= rsz - asize32;
			end
			S_P_NW: n_q <= b_q + rsz;
			default: ;
		endcase
	end

endmodule
